>>> hdl/scfla_pkg.sv
// Shared types and constants of the size-class free-list allocator.
package scfla_pkg;

   localparam int NUM_CLASSES       = 16;
   localparam int GRANULE_BYTES     = 8;
   localparam int MAX_REQUEST_BYTES = 128;
   localparam int ARENA_BYTES       = 65536;

   localparam int NUM_GRANULES = ARENA_BYTES / GRANULE_BYTES;
   localparam int GRAN_SHIFT   = $clog2(GRANULE_BYTES);
   localparam int IDX_W        = $clog2(NUM_GRANULES);
   localparam int BUMP_W       = IDX_W + 1;
   localparam int CLS_W        = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
   localparam int GPB_W        = CLS_W + 1;
   localparam int BATCH_W      = 11;
   localparam int NEED_W       = GPB_W + BATCH_W;
   localparam int SUM_W        = ((NEED_W > BUMP_W) ? NEED_W : BUMP_W) + 1;
   localparam int SIZE_W       = 8;
   localparam int ADDR_W       = 16;
   localparam int STATUS_W     = 2;
   localparam int CSR_IDX_W    = 1;

   localparam logic [BATCH_W-1:0] INIT_BATCH_RESET = 11'd32;
   localparam logic [BATCH_W-1:0] MAX_BATCH_RESET  = 11'd1024;

   localparam logic [CSR_IDX_W-1:0] CSR_INITIAL_BATCH = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_BATCH     = 1'd1;

   localparam logic REQ_ALLOC = 1'b0;
   localparam logic REQ_FREE  = 1'b1;

   localparam logic [STATUS_W-1:0] STAT_DONE     = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_BAD_SIZE = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_NO_MEM   = 2'd2;

   typedef struct packed {
      logic              req_type;
      logic [SIZE_W-1:0] size_bytes;
      logic [ADDR_W-1:0] block_addr;
   } req_payload_type;

   typedef struct packed {
      logic [ADDR_W-1:0]   alloc_addr;
      logic [STATUS_W-1:0] status;
   } rsp_payload_type;

   typedef struct packed {
      logic             valid;
      logic [IDX_W-1:0] idx;
   } link_type;

   typedef struct packed {
      logic accept;
      logic reread;
      logic commit_free;
      logic commit_pop;
      logic carve_start;
      logic carve_step;
      logic rsp_load;
   } ctrl_cmd_type;

   typedef struct packed {
      logic bad;
      logic is_free;
      logic head_valid;
      logic overflow;
      logic carve_last;
      logic out_free;
   } dp_status_type;

endpackage

>>> hdl/size_class_free_list_allocator_top.sv
// Top level of the size-class free-list allocator.
//
// Request channel (req_valid/req_ready/req_data): one item is an allocate or a
// free with a size of 1 to 128 bytes (16 classes of 8-byte steps) and, for a
// free, the block address. Every item gives exactly one result item on the
// response channel (rsp_valid/rsp_ready/rsp_data): the allocated address and
// a status of done, size rejected or out of arena memory.
// Items are handled one at a time, each from accept through the execute state
// to the result register. An allocate from an empty class first carves a batch
// of n blocks through the link memory write port, one block per cycle, then
// re-reads the new head and pops it; no batch is carved if it would overrun
// the arena. n starts at initial_batch, doubles per class refill up to max_batch.
// The result sits in an output register; the next item is accepted while it
// waits, and the block holds that next item's result until rsp_ready.
// Reset empties all class lists, restores the register defaults and rewinds
// the bump pointer; no clearing pass is needed. Write csr_* only while idle.
module size_class_free_list_allocator_top (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  scfla_pkg::req_payload_type      req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output scfla_pkg::rsp_payload_type      rsp_data,
   input  logic                            csr_wr_en,
   input  logic [scfla_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [scfla_pkg::BATCH_W-1:0]   csr_wdata
);
   import scfla_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type st;

   scfla_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .st        (st),
      .cmd       (cmd)
   );

   scfla_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_data  (rsp_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .st        (st)
   );

endmodule

>>> hdl/scfla_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module scfla_ram #(
   parameter int WIDTH = 14,
   parameter int DEPTH = 8192
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/scfla_ctrl.sv
// Sequencer of the allocator: accept, execute, carve a refill batch, re-read.
module scfla_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  scfla_pkg::dp_status_type st,
   output scfla_pkg::ctrl_cmd_type  cmd
);
   import scfla_pkg::*;

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_EXEC   = 2'd1;
   localparam logic [1:0] S_CARVE  = 2'd2;
   localparam logic [1:0] S_REREAD = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            // hold off the sender while reset is applied
            req_ready = !reset;
            if (req_valid && !reset) begin
               cmd.accept = 1'b1;
               state_in   = S_EXEC;
            end
         end
         S_EXEC: begin
            if (!st.bad && !st.is_free && !st.head_valid && !st.overflow) begin
               cmd.carve_start = 1'b1;
               state_in        = S_CARVE;
            end else if (st.out_free) begin
               cmd.rsp_load    = 1'b1;
               cmd.commit_free = !st.bad && st.is_free;
               cmd.commit_pop  = !st.bad && !st.is_free && st.head_valid;
               state_in        = S_IDLE;
            end
         end
         S_CARVE: begin
            cmd.carve_step = 1'b1;
            if (st.carve_last) begin
               state_in = S_REREAD;
            end
         end
         S_REREAD: begin
            // fetch the link of the fresh head, then pop it
            cmd.reread = 1'b1;
            state_in   = S_EXEC;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_carve_follows_exec: assert property (@(posedge clock) disable iff (reset)
      cmd.carve_start |=> state_ff == S_CARVE)
      else $error("carve did not start after refill decision");

   a_reread_to_exec: assert property (@(posedge clock) disable iff (reset)
      cmd.reread |=> state_ff == S_EXEC && !req_ready)
      else $error("re-read not followed by execute");

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      cmd.accept |=> !req_ready)
      else $error("item accepted while previous item still in work");

endmodule

>>> hdl/scfla_dp.sv
// Datapath: class heads, batch sizes, bump pointer, link memory and result register.
module scfla_dp (
   input  logic                                  clock,
   input  logic                                  reset,
   input  scfla_pkg::req_payload_type            req_data,
   output scfla_pkg::rsp_payload_type            rsp_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   input  logic                                  csr_wr_en,
   input  logic [scfla_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [scfla_pkg::BATCH_W-1:0]         csr_wdata,
   input  scfla_pkg::ctrl_cmd_type               cmd,
   output scfla_pkg::dp_status_type              st
);
   import scfla_pkg::*;

   // configuration
   logic [BATCH_W-1:0] cfg_init_ff, cfg_init_in;
   logic [BATCH_W-1:0] cfg_max_ff, cfg_max_in;

   // per-class state
   logic [NUM_CLASSES-1:0] head_valid_ff, head_valid_in;
   logic [IDX_W-1:0]       head_idx_ff [NUM_CLASSES];
   logic [IDX_W-1:0]       head_idx_in [NUM_CLASSES];
   logic [NUM_CLASSES-1:0] used_ff, used_in;
   logic [BATCH_W-1:0]     batch_ff [NUM_CLASSES];
   logic [BATCH_W-1:0]     batch_in [NUM_CLASSES];
   logic [BUMP_W-1:0]      bump_ff, bump_in;

   // latched item
   logic             type_ff, type_in;
   logic             bad_ff, bad_in;
   logic [CLS_W-1:0] cls_ff, cls_in;
   logic [IDX_W-1:0] gran_ff, gran_in;

   // refill walk
   logic [IDX_W-1:0]   cur_ff, cur_in;
   logic [BATCH_W-1:0] cnt_ff, cnt_in;

   // result register
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_ff, rsp_in;

   // decode of the incoming item
   logic [SIZE_W-1:0] size_m1;
   logic [SIZE_W-1:0] cls_wide;
   logic              req_bad;
   logic [CLS_W-1:0]  req_cls;
   logic [IDX_W-1:0]  req_gran;

   // work on the latched class
   logic                     cur_hv;
   logic [IDX_W-1:0]         cur_hidx;
   logic [BATCH_W-1:0]       batch;
   logic [BATCH_W-1:0]       carve_n;
   logic [GPB_W-1:0]         gpb;
   logic [NEED_W-1:0]        need;
   logic                     overflow;
   logic [BATCH_W:0]         dbl;
   logic [BATCH_W-1:0]       batch_next;
   logic [BUMP_W-1:0]        cur_sum;
   logic                     carve_last;
   logic                     out_free;
   logic [IDX_W+GRAN_SHIFT-1:0] byte_addr;

   // link memory ports
   logic             mem_wr_en;
   logic [IDX_W-1:0] mem_wr_addr;
   link_type         mem_wr_data;
   logic             mem_rd_en;
   logic [CLS_W-1:0] rd_cls;
   link_type         mem_rd_data;

   always_comb begin
      size_m1  = req_data.size_bytes - SIZE_W'(1);
      cls_wide = size_m1 >> GRAN_SHIFT;
      req_bad  = (req_data.size_bytes == '0)
              || (req_data.size_bytes > SIZE_W'(MAX_REQUEST_BYTES))
              || (cls_wide >= SIZE_W'(NUM_CLASSES));
      req_cls  = cls_wide[CLS_W-1:0];
      req_gran = IDX_W'(req_data.block_addr >> GRAN_SHIFT);
   end

   always_comb begin
      cur_hv     = head_valid_ff[cls_ff];
      cur_hidx   = head_idx_ff[cls_ff];
      batch      = used_ff[cls_ff] ? batch_ff[cls_ff] : cfg_init_ff;
      carve_n    = (batch == '0) ? BATCH_W'(1) : batch;
      gpb        = GPB_W'(cls_ff) + GPB_W'(1);
      need       = NEED_W'(gpb) * NEED_W'(carve_n);
      overflow   = (SUM_W'(bump_ff) + SUM_W'(need)) > SUM_W'(NUM_GRANULES);
      dbl        = {batch, 1'b0};
      if (batch < cfg_max_ff) begin
         batch_next = (dbl > {1'b0, cfg_max_ff}) ? cfg_max_ff : dbl[BATCH_W-1:0];
      end else begin
         batch_next = batch;
      end
      cur_sum    = BUMP_W'(cur_ff) + BUMP_W'(gpb);
      carve_last = (cnt_ff == BATCH_W'(1));
      out_free   = !rsp_valid_ff || rsp_ready;
      byte_addr  = {cur_hidx, {GRAN_SHIFT{1'b0}}};
   end

   assign st.bad        = bad_ff;
   assign st.is_free    = (type_ff == REQ_FREE);
   assign st.head_valid = cur_hv;
   assign st.overflow   = overflow;
   assign st.carve_last = carve_last;
   assign st.out_free   = out_free;

   // read the head's link at accept, or after a refill
   assign rd_cls    = cmd.accept ? req_cls : cls_ff;
   assign mem_rd_en = cmd.accept || cmd.reread;

   always_comb begin
      mem_wr_en   = cmd.carve_step || cmd.commit_free;
      mem_wr_addr = cmd.carve_step ? cur_ff : gran_ff;
      if (cmd.carve_step) begin
         mem_wr_data.valid = !carve_last;
         mem_wr_data.idx   = cur_sum[IDX_W-1:0];
      end else begin
         mem_wr_data.valid = cur_hv;
         mem_wr_data.idx   = cur_hidx;
      end
   end

   scfla_ram #(
      .WIDTH ($bits(link_type)),
      .DEPTH (NUM_GRANULES)
   ) u_link_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (head_idx_ff[rd_cls]),
      .rd_data (mem_rd_data)
   );

   always_comb begin
      cfg_init_in   = cfg_init_ff;
      cfg_max_in    = cfg_max_ff;
      head_valid_in = head_valid_ff;
      head_idx_in   = head_idx_ff;
      used_in       = used_ff;
      batch_in      = batch_ff;
      bump_in       = bump_ff;
      type_in       = type_ff;
      bad_in        = bad_ff;
      cls_in        = cls_ff;
      gran_in       = gran_ff;
      cur_in        = cur_ff;
      cnt_in        = cnt_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_in        = rsp_ff;

      if (csr_wr_en) begin
         case (csr_index)
            CSR_INITIAL_BATCH: cfg_init_in = csr_wdata;
            CSR_MAX_BATCH:     cfg_max_in  = csr_wdata;
            default: ;
         endcase
      end

      if (cmd.accept) begin
         type_in = req_data.req_type;
         bad_in  = req_bad;
         cls_in  = req_cls;
         gran_in = req_gran;
      end

      if (cmd.carve_start) begin
         cur_in = bump_ff[IDX_W-1:0];
         cnt_in = carve_n;
      end

      if (cmd.carve_step) begin
         cur_in = cur_sum[IDX_W-1:0];
         cnt_in = cnt_ff - BATCH_W'(1);
         if (carve_last) begin
            // batch is linked: hand it to the class and bump the arena
            head_valid_in[cls_ff] = 1'b1;
            head_idx_in[cls_ff]   = bump_ff[IDX_W-1:0];
            bump_in               = cur_sum;
            used_in[cls_ff]       = 1'b1;
            batch_in[cls_ff]      = batch_next;
         end
      end

      if (cmd.commit_pop) begin
         head_valid_in[cls_ff] = mem_rd_data.valid;
         head_idx_in[cls_ff]   = mem_rd_data.idx;
      end

      if (cmd.commit_free) begin
         head_valid_in[cls_ff] = 1'b1;
         head_idx_in[cls_ff]   = gran_ff;
      end

      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
         if (bad_ff) begin
            rsp_in.status     = STAT_BAD_SIZE;
            rsp_in.alloc_addr = '0;
         end else if (type_ff == REQ_FREE) begin
            rsp_in.status     = STAT_DONE;
            rsp_in.alloc_addr = '0;
         end else if (cur_hv) begin
            rsp_in.status     = STAT_DONE;
            rsp_in.alloc_addr = ADDR_W'(byte_addr);
         end else begin
            rsp_in.status     = STAT_NO_MEM;
            rsp_in.alloc_addr = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_init_ff   <= INIT_BATCH_RESET;
         cfg_max_ff    <= MAX_BATCH_RESET;
         head_valid_ff <= '0;
         used_ff       <= '0;
         bump_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         cfg_init_ff   <= cfg_init_in;
         cfg_max_ff    <= cfg_max_in;
         head_valid_ff <= head_valid_in;
         used_ff       <= used_in;
         bump_ff       <= bump_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      head_idx_ff <= head_idx_in;
      batch_ff    <= batch_in;
      type_ff     <= type_in;
      bad_ff      <= bad_in;
      cls_ff      <= cls_in;
      gran_ff     <= gran_in;
      cur_ff      <= cur_in;
      cnt_ff      <= cnt_in;
      rsp_ff      <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_load_into_free_slot: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> out_free)
      else $error("result loaded over an item not yet taken");

   a_pop_reports_done: assert property (@(posedge clock) disable iff (reset)
      cmd.commit_pop |=> rsp_valid_ff && rsp_ff.status == STAT_DONE)
      else $error("pop did not present a done item");

   a_refill_sets_head: assert property (@(posedge clock) disable iff (reset)
      cmd.carve_step && carve_last |=> head_valid_ff[cls_ff])
      else $error("class head not valid after refill");

   a_bump_in_arena: assert property (@(posedge clock) disable iff (reset)
      bump_ff <= BUMP_W'(NUM_GRANULES))
      else $error("bump pointer past arena end");

endmodule

>>> verif/size_class_free_list_allocator_top_tb.sv
// Self-checking testbench for the size-class free-list allocator top level.
module size_class_free_list_allocator_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import scfla_pkg::*;

   localparam int RSP_HOLD_CYCLES = 300;
   localparam int STALL_LIMIT     = 5000;

   // Tracks class lists, refill batches, the link store and the bump pointer.
   class alloc_scoreboard;
      bit                     head_ok[NUM_CLASSES];
      logic [IDX_W-1:0]       head_at[NUM_CLASSES];
      bit                     refilled[NUM_CLASSES];
      logic [BATCH_W-1:0]     batch_now[NUM_CLASSES];
      bit                     link_ok[NUM_GRANULES];
      logic [IDX_W-1:0]       link_to[NUM_GRANULES];
      int unsigned            bump;
      logic [BATCH_W-1:0]     init_batch;
      logic [BATCH_W-1:0]     max_batch;
      rsp_payload_type        expected_q[$];
      int                     mismatches;

      function new();
         init_batch = INIT_BATCH_RESET;
         max_batch  = MAX_BATCH_RESET;
         bump       = 0;
         mismatches = 0;
         for (int i = 0; i < NUM_CLASSES; i++) begin
            head_at[i]   = '0;
            batch_now[i] = '0;
         end
         for (int i = 0; i < NUM_GRANULES; i++) link_to[i] = '0;
      endfunction

      function void set_reg(logic [CSR_IDX_W-1:0] idx, int value);
         if (idx == CSR_INITIAL_BATCH) init_batch = BATCH_W'(value);
         else max_batch = BATCH_W'(value);
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      function void report(string what, logic [31:0] want, logic [31:0] got);
         mismatches++;
         if (mismatches <= 10)
            $display("MISMATCH %s: expected %0h, got %0h", what, want, got);
      endfunction

      // Predict the result of one accepted item and queue it.
      function rsp_payload_type note(req_payload_type it);
         rsp_payload_type  res;
         int               c;
         int unsigned      blk;
         int unsigned      batch;
         int unsigned      n;
         int unsigned      base;
         int unsigned      cur;
         logic [IDX_W-1:0] g;
         res        = '0;
         res.status = STAT_DONE;
         if (it.size_bytes == 0 || it.size_bytes > MAX_REQUEST_BYTES) c = -1;
         else c = (int'(it.size_bytes) + GRANULE_BYTES - 1) / GRANULE_BYTES - 1;
         if (c >= NUM_CLASSES) c = -1;
         if (c < 0) begin
            res.status = STAT_BAD_SIZE;
         end else if (it.req_type == REQ_ALLOC) begin
            if (!head_ok[c]) begin
               // empty list: carve a batch in address order
               blk   = GRANULE_BYTES * (c + 1);
               batch = refilled[c] ? batch_now[c] : init_batch;
               n     = (batch == 0) ? 1 : batch;
               if (bump + blk * n > ARENA_BYTES) begin
                  res.status = STAT_NO_MEM;
               end else begin
                  base = bump / GRANULE_BYTES;
                  for (int unsigned i = 0; i < n; i++) begin
                     cur          = base + i * (c + 1);
                     link_ok[cur] = (i + 1 < n);
                     link_to[cur] = IDX_W'(cur + c + 1);
                  end
                  head_ok[c] = 1'b1;
                  head_at[c] = IDX_W'(base);
                  bump       = bump + blk * n;
                  if (batch < max_batch) begin
                     batch = batch * 2;
                     if (batch > max_batch) batch = max_batch;
                  end
                  batch_now[c] = BATCH_W'(batch);
                  refilled[c]  = 1'b1;
               end
            end
            if (res.status == STAT_DONE) begin
               g              = head_at[c];
               head_ok[c]     = link_ok[g];
               head_at[c]     = link_to[g];
               res.alloc_addr = ADDR_W'(g) << GRAN_SHIFT;
            end
         end else begin
            g          = IDX_W'(it.block_addr >> GRAN_SHIFT);
            link_ok[g] = head_ok[c];
            link_to[g] = head_at[c];
            head_ok[c] = 1'b1;
            head_at[c] = g;
         end
         expected_q.push_back(res);
         return res;
      endfunction

      function void check(rsp_payload_type got);
         rsp_payload_type want;
         if (expected_q.size() == 0) begin
            report("result with no item pending", '0, 32'(got));
            return;
         end
         want = expected_q.pop_front();
         if (got.alloc_addr !== want.alloc_addr)
            report("alloc_addr", 32'(want.alloc_addr), 32'(got.alloc_addr));
         if (got.status !== want.status)
            report("status", 32'(want.status), 32'(got.status));
      endfunction
   endclass

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   req_payload_type      req_data;
   logic                 rsp_valid;
   logic                 rsp_ready;
   rsp_payload_type      rsp_data;
   logic                 csr_wr_en;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [BATCH_W-1:0]   csr_wdata;

   alloc_scoreboard      sb = new();
   logic [ADDR_W-1:0]    live_addr[$];
   logic [SIZE_W-1:0]    live_size[$];
   bit                   calm = 1'b0;
   bit                   hold_rsp = 1'b0;
   int                   quiet_cycles = 0;

   size_class_free_list_allocator_top i_dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 75) return $urandom_range(1, 3);
      if (r < 95) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // Offer one item, hold it until accepted, then maybe idle.
   task automatic issue(input logic rt, input logic [SIZE_W-1:0] sz,
                        input logic [ADDR_W-1:0] ad, input bit park);
      req_payload_type it;
      rsp_payload_type res;
      int              gap;
      it.req_type   = rt;
      it.size_bytes = sz;
      it.block_addr = ad;
      gap = (calm || $urandom_range(0, 99) < 55) ? 0 : idle_len();
      if (park && gap == 0) gap = 1;
      req_data  <= it;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      res = sb.note(it);
      if (rt == REQ_ALLOC && res.status == STAT_DONE) begin
         live_addr.push_back(res.alloc_addr);
         live_size.push_back(sz);
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      while (sb.pending() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic set_batches(input int init_v, input int max_v);
      wait_drained();
      csr_wr_en <= 1'b1;
      csr_index <= CSR_INITIAL_BATCH;
      csr_wdata <= BATCH_W'(init_v);
      @(posedge clock);
      csr_index <= CSR_MAX_BATCH;
      csr_wdata <= BATCH_W'(max_v);
      @(posedge clock);
      csr_wr_en <= 1'b0;
      sb.set_reg(CSR_INITIAL_BATCH, init_v);
      sb.set_reg(CSR_MAX_BATCH, max_v);
   endtask

   // Mostly allocate/free pairs on live blocks, plus rejected sizes and stray frees.
   task automatic run_random(input int count, input int hold_at, input int drain_at);
      int                r;
      int                pick;
      int                cls;
      logic              rt;
      logic [SIZE_W-1:0] sz;
      logic [ADDR_W-1:0] ad;
      for (int k = 0; k < count; k++) begin
         if (k % 40 == 0) calm = ($urandom_range(0, 3) == 0);
         if (k == hold_at) hold_rsp = 1'b1;
         r  = $urandom_range(0, 99);
         ad = ADDR_W'($urandom_range(0, 65535));
         rt = REQ_ALLOC;
         if (r < 4) begin
            rt = $urandom_range(0, 1) ? REQ_FREE : REQ_ALLOC;
            sz = ($urandom_range(0, 3) == 0) ? '0 : SIZE_W'($urandom_range(129, 255));
         end else if (r < 9) begin
            rt = REQ_FREE;
            sz = SIZE_W'($urandom_range(1, MAX_REQUEST_BYTES));
         end else if (live_addr.size() > 0 && (live_addr.size() > 40 || r < 50)) begin
            pick = $urandom_range(0, live_addr.size() - 1);
            cls  = (int'(live_size[pick]) + GRANULE_BYTES - 1) / GRANULE_BYTES - 1;
            rt   = REQ_FREE;
            sz   = SIZE_W'(cls * GRANULE_BYTES + $urandom_range(1, GRANULE_BYTES));
            ad   = live_addr[pick];
            // occasionally dirty the low bits, which the block must ignore
            if ($urandom_range(0, 7) == 0)
               ad[GRAN_SHIFT-1:0] = GRAN_SHIFT'($urandom_range(1, GRANULE_BYTES - 1));
            live_addr.delete(pick);
            live_size.delete(pick);
         end else begin
            sz = SIZE_W'($urandom_range(1, MAX_REQUEST_BYTES));
         end
         issue(rt, sz, ad, (k == count - 1) || (k == drain_at));
         if (k == drain_at) wait_drained();
      end
      calm = 1'b0;
   endtask

   // Result side: check every accepted item, stall at random or on request.
   initial begin
      int stall_left;
      stall_left = 0;
      rsp_ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready) sb.check(rsp_data);
         if (stall_left == 0 && hold_rsp) begin
            stall_left = RSP_HOLD_CYCLES;
            hold_rsp   = 1'b0;
         end else if (stall_left == 0 && !calm && $urandom_range(0, 99) < 20) begin
            stall_left = idle_len();
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("size_class_free_list_allocator_top verification failed");
            $finish;
         end
      end
   end

   initial begin
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      csr_wr_en <= 1'b0;
      csr_index <= CSR_INITIAL_BATCH;
      csr_wdata <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // reset batch settings: first refills, rejected sizes, odd frees
      issue(REQ_ALLOC, 8'd1,   16'h0000, 1'b0);
      issue(REQ_ALLOC, 8'd128, 16'hFFFF, 1'b0);
      issue(REQ_ALLOC, 8'd0,   16'h0000, 1'b0);
      issue(REQ_ALLOC, 8'd129, 16'hAAAA, 1'b0);
      issue(REQ_FREE,  8'd255, 16'hFFFF, 1'b0);
      issue(REQ_FREE,  8'd0,   16'h1234, 1'b0);
      issue(REQ_FREE,  8'd8,   16'h0000, 1'b0);
      issue(REQ_ALLOC, 8'd5,   16'h0000, 1'b0);
      issue(REQ_FREE,  8'd9,   16'd263,  1'b0);
      issue(REQ_ALLOC, 8'd16,  16'h0000, 1'b0);
      issue(REQ_FREE,  8'd64,  16'hFFFF, 1'b0);
      issue(REQ_ALLOC, 8'd57,  16'h0000, 1'b0);
      issue(REQ_FREE,  8'd120, 16'h5555, 1'b1);

      // a zero batch still carves one block
      set_batches(0, 1024);
      issue(REQ_ALLOC, 8'd24, 16'h0000, 1'b0);
      issue(REQ_ALLOC, 8'd24, 16'h0000, 1'b0);
      issue(REQ_ALLOC, 8'd17, 16'h0000, 1'b1);

      // batch above the limit stays as it is
      set_batches(64, 16);
      issue(REQ_ALLOC, 8'd32, 16'h0000, 1'b0);
      issue(REQ_ALLOC, 8'd32, 16'h0000, 1'b0);
      issue(REQ_ALLOC, 8'd25, 16'h0000, 1'b1);

      // pop the stray block, then a refill that overruns the arena
      set_batches(1024, 1024);
      issue(REQ_ALLOC, 8'd120, 16'h0000, 1'b0);
      issue(REQ_ALLOC, 8'd120, 16'h0000, 1'b1);

      set_batches(1, 1);
      run_random(300, -1, 150);
      set_batches(4, 64);
      run_random(300, 100, -1);
      set_batches($urandom_range(1, 8), $urandom_range(8, 32));
      run_random(530, -1, -1);
      set_batches(1024, 1024);
      run_random(200, 60, -1);

      wait_drained();
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("size_class_free_list_allocator_top verification clean");
      end else begin
         $display("size_class_free_list_allocator_top verification failed");
      end
      $finish;
   end

endmodule
